/* hw/rtl/rfsm_pkg.sv */
// Package for the RF power and SWR meter: widths, register indexes, reset values.
// Used by the channel interfaces and every module of the block.
package rfsm_pkg;

  localparam int unsigned MvW      = 14;
  localparam int unsigned PwrW     = 12;
  localparam int unsigned SwrW     = 10;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;
  // Power in units of 1e-8 W: 255*16383^2 + 127*16383*10000 fits in 37 bits.
  localparam int unsigned NW       = 37;
  localparam int unsigned SqrtFracBitsDef = 16;

  typedef enum logic [CfgIdxW-1:0] {
    RegSquareGain  = 2'd0,
    RegLinearGain  = 2'd1,
    RegStartPower  = 2'd2,
    RegSwrOffset   = 2'd3
  } cfg_reg_e;

  localparam logic [7:0] SquareGainRst = 8'd114;
  localparam logic [6:0] LinearGainRst = 7'd4;
  localparam logic [6:0] StartPowerRst = 7'd10;
  localparam logic [7:0] SwrOffsetRst  = 8'd0;

  typedef struct packed {
    logic [7:0] square_gain;
    logic [6:0] linear_gain;
    logic [6:0] start_power;
    logic [7:0] swr_offset;
  } cfg_t;

  typedef struct packed {
    logic [MvW-1:0] forward_mv;
    logic [MvW-1:0] reflected_mv;
  } in_item_t;

  typedef struct packed {
    logic [PwrW-1:0] power_tenths;
    logic [SwrW-1:0] swr_hundredths;
  } out_item_t;

endpackage

/* hw/rtl/rfsm_in_if.sv */
// Input channel of the meter: valid/ready handshake with one detector pair.
// Depends on rfsm_pkg.
interface rfsm_in_if;
  import rfsm_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/rfsm_out_if.sv */
// Output channel of the meter: valid/ready handshake with power and SWR.
// Depends on rfsm_pkg.
interface rfsm_out_if;
  import rfsm_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/rf_power_and_swr_meter.sv */
// RF power and SWR meter: a fully pipelined datapath from detector pair to result.
//
// Channels: in_if carries forward_mv and reflected_mv (14 bits each); out_if
// carries power_tenths (12 bits) and swr_hundredths (10 bits). An item moves
// when valid and ready are both high. Configuration is a write port with
// cfg_we_i, cfg_idx_i and cfg_data_i; write it only while the block is idle.
// Throughput: one item per cycle while the receiver accepts results. The
// pipeline is the divider (2*SQRT_FRAC_BITS stages, one
// quotient bit each), the square root (SQRT_FRAC_BITS stages), the five power
// and rounding stages before them, and the gamma stage, ten SWR search stages
// and the output register after them.
// The whole pipeline advances together; when the receiver holds ready low with
// a result waiting, every stage holds and in_if.ready falls, so no item is
// lost or repeated. Reset clears every valid bit and loads the register
// defaults; there is no clearing pass.
module rf_power_and_swr_meter
  import rfsm_pkg::*;
#(
  parameter int unsigned SQRT_FRAC_BITS = SqrtFracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  rfsm_in_if.sink             in_if,
  rfsm_out_if.source          out_if
);

  localparam int unsigned K  = SQRT_FRAC_BITS;
  localparam int unsigned GW = K + 1;
  // Tag carried through divider and root: power, low-power flag, ge flag.
  localparam int unsigned TW = PwrW + 2;

  cfg_t cfg;
  logic en;

  rfsm_cfg_regs u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cfg_o(cfg)
  );

  // Stall everything when a result waits and the receiver is not ready.
  assign en           = !out_if.valid || out_if.ready;
  assign in_if.ready  = en;

  // Stage 1: products A*v and B*v (one multiplier per product and channel).
  logic           v1_q;
  logic [MvW-1:0] fmv1_q, rmv1_q;
  logic [21:0]    fa1_q, ra1_q;
  logic [20:0]    fb1_q, rb1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_if.valid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      fmv1_q <= in_if.data.forward_mv;
      rmv1_q <= in_if.data.reflected_mv;
      fa1_q  <= 22'(cfg.square_gain * in_if.data.forward_mv);
      ra1_q  <= 22'(cfg.square_gain * in_if.data.reflected_mv);
      fb1_q  <= 21'(cfg.linear_gain * in_if.data.forward_mv);
      rb1_q  <= 21'(cfg.linear_gain * in_if.data.reflected_mv);
    end
  end

  // Stage 2: N = (A*v)*v + (B*v)*10000.
  logic          v2_q;
  logic [NW-1:0] nf2_q, nr2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      nf2_q <= NW'(fa1_q * fmv1_q) + NW'(fb1_q * 14'd10000);
      nr2_q <= NW'(ra1_q * rmv1_q) + NW'(rb1_q * 14'd10000);
    end
  end

  // Stage 3: power = floor((N + 5e6) / 1e7), with 1e7 = 2^7 * 78125.
  // Shift by 7, then divide by 78125 via reciprocal with correction.
  logic          v3_q;
  logic [NW-1:0] nf3_q, nr3_q;
  logic [NW-1:0] t3_q;
  logic [NW-1:0] tsum;

  assign tsum = nf2_q + NW'(5000000);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      nf3_q <= nf2_q;
      nr3_q <= nr2_q;
      t3_q  <= tsum;
    end
  end

  // Stage 4: quotient estimate (t>>7) * ceil(2^32/78125) >> 32, t>>7 < 2^30.
  localparam logic [15:0] Recip = 16'd54976;
  logic          v4_q;
  logic [NW-1:0] nf4_q, nr4_q;
  logic [29:0]   u4_q;
  logic [45:0]   prod4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      nf4_q   <= nf3_q;
      nr4_q   <= nr3_q;
      u4_q    <= t3_q[36:7];
      prod4_q <= 46'(t3_q[36:7] * Recip);
    end
  end

  // Stage 5: correct the estimate by one, saturate, compare start power and Nr >= Nf.
  logic          v5_q;
  logic [NW-1:0] nf5_q, nr5_q;
  logic [PwrW-1:0] pwr5_q;
  logic          low5_q, ge5_q;
  logic [14:0]   qest;
  logic [31:0]   back;
  logic [14:0]   qfix;
  logic [PwrW-1:0] pwr_sat;

  always_comb begin
    qest    = {1'b0, prod4_q[45:32]};
    back    = 32'(qest * 17'd78125);
    qfix    = (32'(u4_q) < back) ? qest - 15'd1 : qest;
    pwr_sat = (qfix > 15'd4095) ? PwrW'(4095) : qfix[PwrW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      nf5_q  <= nf4_q;
      nr5_q  <= nr4_q;
      pwr5_q <= pwr_sat;
      low5_q <= pwr_sat < PwrW'(cfg.start_power);
      ge5_q  <= nr4_q >= nf4_q;
    end
  end

  // Divider: floor(Nr * 2^(2K) / Nf); only meaningful when Nr < Nf.
  logic          vd;
  logic [2*K-1:0] qd;
  logic [TW-1:0] tagd;

  rfsm_divider #(.QW(2*K), .TW(TW)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v5_q),
    .num_i(ge5_q ? '0 : nr5_q), .den_i(ge5_q ? NW'(1) : nf5_q),
    .tag_i({pwr5_q, low5_q, ge5_q}),
    .valid_o(vd), .quo_o(qd), .tag_o(tagd)
  );

  logic          vs;
  logic [K-1:0]  g;
  logic [TW-1:0] tags;

  rfsm_sqrt #(.K(K), .TW(TW)) u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vd), .x_i(qd), .tag_i(tagd),
    .valid_o(vs), .root_o(g), .tag_o(tags)
  );

  // Stage 6: num = S+g, den = S-g, high-SWR test. g < S always holds here.
  logic          v6_q;
  logic [TW-1:0] tag6_q;
  logic [GW:0]   num6_q;
  logic [GW:0]   den6_q;
  logic          hi6_q;
  logic [GW:0]   numc, denc;

  assign numc = (GW+1)'(1 << K) + (GW+1)'(g);
  assign denc = (GW+1)'(1 << K) - (GW+1)'(g);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en) v6_q <= vs;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      tag6_q <= tags;
      num6_q <= numc;
      den6_q <= denc;
      hi6_q  <= ((GW+15)'(numc) * (GW+15)'(1000)) > ((GW+15)'(denc) * (GW+15)'(9985));
    end
  end

  // SWR = floor((200*num + den) / (2*den)) lies in 100..999 when not high;
  // found by a pipelined search of ten bits, one per stage (steps 7..16).
  localparam int unsigned DW = GW + 12;
  logic          vq  [SwrW+1];
  logic [TW-1:0] tq  [SwrW+1];
  logic          hq  [SwrW+1];
  logic [DW-1:0] rq  [SwrW+1];
  logic [DW-1:0] dq  [SwrW+1];
  logic [SwrW-1:0] qq[SwrW+1];

  always_comb begin
    vq[0] = v6_q;
    tq[0] = tag6_q;
    hq[0] = hi6_q;
    rq[0] = DW'(num6_q * 8'd200) + DW'(den6_q);
    dq[0] = DW'({den6_q, 1'b0});
    qq[0] = '0;
  end

  for (genvar b = 0; b < SwrW; b++) begin : g_swr
    localparam int unsigned Bit = SwrW - 1 - b;
    logic [DW+SwrW-1:0] trial;
    logic               take;
    assign trial = (DW+SwrW)'(dq[b]) << Bit;
    assign take  = (DW+SwrW)'(rq[b]) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vq[b+1] <= 1'b0;
      else if (en) vq[b+1] <= vq[b];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        tq[b+1] <= tq[b];
        hq[b+1] <= hq[b];
        dq[b+1] <= dq[b];
        rq[b+1] <= take ? DW'((DW+SwrW)'(rq[b]) - trial) : rq[b];
        qq[b+1] <= take ? qq[b] | SwrW'(1 << Bit) : qq[b];
      end
    end
  end

  // Output stage: special cases, offset and clamp.
  logic [PwrW-1:0] fpwr;
  logic            flow, fge;
  logic signed [11:0] sval;
  logic [SwrW-1:0]  swr;
  logic            vout_q;
  out_item_t       out_q;

  always_comb begin
    {fpwr, flow, fge} = tq[SwrW];
    sval = (hq[SwrW] ? 12'sd999 : $signed({2'b00, qq[SwrW]}))
         + 12'($signed(cfg.swr_offset));
    priority if (flow) swr = '0;
    else if (fge) swr = SwrW'(999);
    else if (sval < 12'sd100) swr = SwrW'(100);
    else if (sval > 12'sd999) swr = SwrW'(999);
    else swr = sval[SwrW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vout_q <= 1'b0;
    else if (en) vout_q <= vq[SwrW];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.power_tenths   <= fpwr;
      out_q.swr_hundredths <= swr;
    end
  end

  assign out_if.valid = vout_q;
  assign out_if.data  = out_q;

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data))
    else $error("result changed under stall");

  // Ready follows the output register and the receiver's ready only.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready == (!out_if.valid || out_if.ready))
    else $error("input ready mismatch");

  // The gamma pipeline never sees g at or above one.
  a_gamma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vs && !tags[0] |-> g < (K+1)'(1 << K))
    else $error("gamma out of range");

  // A searched SWR that is not high stays below 1000.
  a_swr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vq[SwrW] && !hq[SwrW] && !tq[SwrW][0] |-> qq[SwrW] <= SwrW'(999))
    else $error("SWR search overflow");

endmodule

/* hw/rtl/rfsm_cfg_regs.sv */
// Configuration registers of the meter, written through a plain write port.
// Depends on rfsm_pkg.
module rfsm_cfg_regs
  import rfsm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  // Register write; every index of the two-bit field names a register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.square_gain <= SquareGainRst;
      cfg_q.linear_gain <= LinearGainRst;
      cfg_q.start_power <= StartPowerRst;
      cfg_q.swr_offset  <= SwrOffsetRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegSquareGain: cfg_q.square_gain <= cfg_data_i;
        RegLinearGain: cfg_q.linear_gain <= cfg_data_i[6:0];
        RegStartPower: cfg_q.start_power <= cfg_data_i[6:0];
        RegSwrOffset:  cfg_q.swr_offset  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/rfsm_divider.sv */
// Pipelined restoring fractional divider: q = floor(num * 2^QW / den), num < den.
// One quotient bit per stage; depends on rfsm_pkg only for the item widths.
module rfsm_divider
  import rfsm_pkg::*;
#(
  parameter int unsigned QW  = 32,
  parameter int unsigned TW  = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [NW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);

  logic [QW:0]   vld_q;
  logic [NW-1:0] rem_q [QW+1];
  logic [NW-1:0] den_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic [TW-1:0] tag_q [QW+1];

  always_comb begin
    vld_q[0] = valid_i;
    rem_q[0] = num_i;
    den_q[0] = den_i;
    quo_q[0] = '0;
    tag_q[0] = tag_i;
  end

  // One subtract-and-compare per stage.
  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [NW:0] sh;
    logic        ge;
    assign sh = {rem_q[s], 1'b0};
    assign ge = sh >= {1'b0, den_q[s]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= ge ? NW'(sh - {1'b0, den_q[s]}) : NW'(sh);
        den_q[s+1] <= den_q[s];
        quo_q[s+1] <= {quo_q[s][QW-2:0], ge};
        tag_q[s+1] <= tag_q[s];
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign quo_o   = quo_q[QW];
  assign tag_o   = tag_q[QW];

endmodule

/* hw/rtl/rfsm_sqrt.sv */
// Pipelined integer square root of a 2K-bit value, one result bit per stage.
// Depends on rfsm_pkg.
module rfsm_sqrt
  import rfsm_pkg::*;
#(
  parameter int unsigned K  = 16,
  parameter int unsigned TW = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [2*K-1:0] x_i,
  input  logic [TW-1:0]  tag_i,
  output logic           valid_o,
  output logic [K-1:0]   root_o,
  output logic [TW-1:0]  tag_o
);

  logic [K:0]     vld_q;
  logic [2*K-1:0] x_q   [K+1];
  logic [K+1:0]   rem_q [K+1];
  logic [K-1:0]   root_q[K+1];
  logic [TW-1:0]  tag_q [K+1];

  always_comb begin
    vld_q[0]  = valid_i;
    x_q[0]    = x_i;
    rem_q[0]  = '0;
    root_q[0] = '0;
    tag_q[0]  = tag_i;
  end

  // Digit-by-digit root: bring down two bits, try 4*root+1.
  for (genvar s = 0; s < K; s++) begin : g_stage
    logic [K+1:0] r2;
    logic [K+1:0] trial;
    logic         ge;
    assign r2    = {rem_q[s][K-1:0], x_q[s][2*K-1 -: 2]};
    assign trial = {root_q[s], 2'b01};
    assign ge    = r2 >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[s+1]    <= {x_q[s][2*K-3:0], 2'b00};
        rem_q[s+1]  <= ge ? r2 - trial : r2;
        root_q[s+1] <= {root_q[s][K-2:0], ge};
        tag_q[s+1]  <= tag_q[s];
      end
    end
  end

  assign valid_o = vld_q[K];
  assign root_o  = root_q[K];
  assign tag_o   = tag_q[K];

endmodule
